FILE: rtl/core/sb64_pkg.sv
// ----------------------------------------------------------------------------
// sb64_pkg
// Shared types, constants and the character lookup for the strict base64
// decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sb64_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam int MAX_BYTES_WIDTH = 32;
   localparam logic [MAX_BYTES_WIDTH-1:0] MAX_BYTES_RESET = '1;

   localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_CAPACITY  = 2'd2
   } status_type;

   // Everything that one input item produces: up to three bytes and an
   // optional closing status.
   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  nbytes;
      logic        has_status;
      status_type  status;
   } bundle_type;

   // Returns {valid, sextet}.
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/sb64_step.sv
// ----------------------------------------------------------------------------
// sb64_step
// Input register, stream state and the per-character decode. Produces the
// result bundle of one item in the cycle the item leaves the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sb64_step #(
   parameter int COUNT_WIDTH = sb64_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [sb64_pkg::MAX_BYTES_WIDTH-1:0]  csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_char_code,
   input  logic                                  req_is_last,
   input  logic                                  req_is_empty,
   input  logic                                  ser_free,
   output logic                                  bnd_load,
   output sb64_pkg::bundle_type                  bnd
);
   import sb64_pkg::*;

   localparam int BW    = COUNT_WIDTH + 2;
   localparam int CMP_W = (BW > MAX_BYTES_WIDTH) ? BW : MAX_BYTES_WIDTH;

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_char_ff;
   logic                       in_last_ff;
   logic                       in_empty_ff;

   logic [MAX_BYTES_WIDTH-1:0] max_bytes_ff;
   logic [23:0]                group_bits_ff, group_bits_in;
   logic [1:0]                 group_pos_ff, group_pos_in;
   logic [2:0]                 pad_count_ff, pad_count_in;
   logic                       padded_seen_ff, padded_seen_in;
   logic                       malformed_ff, malformed_in;
   logic                       capacity_ff, capacity_in;
   logic [BW-1:0]              budget_ff, budget_in;

   logic                       step_go;
   logic                       has_result;
   logic                       req_take;
   bundle_type                 bnd_c;

   always_comb begin
      logic [6:0]    sx;
      logic [5:0]    v;
      logic [BW:0]   sum;
      logic          none_seen;

      group_bits_in  = group_bits_ff;
      group_pos_in   = group_pos_ff;
      pad_count_in   = pad_count_ff;
      padded_seen_in = padded_seen_ff;
      malformed_in   = malformed_ff;
      capacity_in    = capacity_ff;
      budget_in      = budget_ff;
      bnd_c          = '0;
      bnd_c.status   = ST_OK;
      sx             = sextet_of(in_char_ff);
      v              = 6'd0;
      sum            = {1'b0, budget_ff} + (BW+1)'(3);
      none_seen      = 1'b0;

      if (!in_empty_ff) begin
         if (group_pos_ff == 2'd0 && padded_seen_ff) begin
            malformed_in = 1'b1;
         end
         if (in_char_ff == PAD_CHAR) begin
            if (pad_count_ff != 3'd7) begin
               pad_count_in = pad_count_ff + 3'd1;
            end
         end else if (pad_count_ff != 3'd0 || !sx[6]) begin
            malformed_in = 1'b1;
         end else begin
            v = sx[5:0];
         end
         group_bits_in = {group_bits_ff[17:0], v};

         if (group_pos_ff == 2'd3) begin
            if (pad_count_in > 3'd2) begin
               malformed_in = 1'b1;
            end
            if (pad_count_in != 3'd0) begin
               padded_seen_in = 1'b1;
            end
            // Saturate at all ones when the add carries out.
            budget_in = sum[BW] ? '1 : sum[BW-1:0];
            if (CMP_W'(budget_in) > CMP_W'(max_bytes_ff)) begin
               capacity_in = 1'b1;
            end
            bnd_c.bytes = group_bits_in;
            if (!malformed_in && !capacity_in) begin
               case (pad_count_in)
                  3'd0:    bnd_c.nbytes = 2'd3;
                  3'd1:    bnd_c.nbytes = 2'd2;
                  default: bnd_c.nbytes = 2'd1;
               endcase
            end
            group_pos_in  = 2'd0;
            group_bits_in = 24'd0;
            pad_count_in  = 3'd0;
         end else begin
            group_pos_in = group_pos_ff + 2'd1;
         end
      end

      if (in_last_ff) begin
         none_seen        = (group_pos_in == 2'd0) && (budget_in == '0);
         bnd_c.has_status = 1'b1;
         if (capacity_in || none_seen || group_pos_in != 2'd0) begin
            bnd_c.status = ST_CAPACITY;
         end else if (malformed_in) begin
            bnd_c.status = ST_MALFORMED;
         end else begin
            bnd_c.status = ST_OK;
         end
         group_bits_in  = 24'd0;
         group_pos_in   = 2'd0;
         pad_count_in   = 3'd0;
         padded_seen_in = 1'b0;
         malformed_in   = 1'b0;
         capacity_in    = 1'b0;
         budget_in      = '0;
      end
   end

   assign has_result = bnd_c.has_status || (bnd_c.nbytes != 2'd0);
   // An item without results never waits for the serializer.
   assign step_go    = in_valid_ff && (ser_free || !has_result);
   assign req_stall  = in_valid_ff && !step_go;
   assign req_take   = req_valid && !req_stall;
   assign bnd_load   = step_go && has_result;
   assign bnd        = bnd_c;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff  <= req_char_code;
         in_last_ff  <= req_is_last;
         in_empty_ff <= req_is_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         max_bytes_ff   <= MAX_BYTES_RESET;
         group_bits_ff  <= 24'd0;
         group_pos_ff   <= 2'd0;
         pad_count_ff   <= 3'd0;
         padded_seen_ff <= 1'b0;
         malformed_ff   <= 1'b0;
         capacity_ff    <= 1'b0;
         budget_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            max_bytes_ff <= csr_wr_data;
         end
         if (step_go) begin
            group_bits_ff  <= group_bits_in;
            group_pos_ff   <= group_pos_in;
            pad_count_ff   <= pad_count_in;
            padded_seen_ff <= padded_seen_in;
            malformed_ff   <= malformed_in;
            capacity_ff    <= capacity_in;
            budget_ff      <= budget_in;
         end
      end
   end

endmodule

FILE: rtl/core/sb64_serializer.sv
// ----------------------------------------------------------------------------
// sb64_serializer
// Holds the result bundle of one item and hands its bytes and closing status
// to the result channel, one transfer per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sb64_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 bnd_load,
   input  sb64_pkg::bundle_type bnd,
   output logic                 ser_free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_data_byte,
   output logic                 rsp_final_res,
   output logic [1:0]           rsp_status
);
   import sb64_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  last_idx_ff;
   logic [1:0]  nbytes_ff;
   logic [23:0] bytes_ff;
   status_type  status_ff;

   logic        xfer;
   logic        at_last;
   logic        is_status;

   assign xfer      = valid_ff && !rsp_stall;
   assign at_last   = (pos_ff == last_idx_ff);
   assign ser_free  = !valid_ff || (xfer && at_last);
   assign is_status = (pos_ff >= nbytes_ff);

   assign rsp_valid     = valid_ff;
   assign rsp_final_res = is_status;
   assign rsp_status    = is_status ? status_ff : ST_OK;

   always_comb begin
      case (pos_ff)
         2'd0:    rsp_data_byte = bytes_ff[23:16];
         2'd1:    rsp_data_byte = bytes_ff[15:8];
         2'd2:    rsp_data_byte = bytes_ff[7:0];
         default: rsp_data_byte = 8'd0;
      endcase
      if (is_status) begin
         rsp_data_byte = 8'd0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (bnd_load) begin
         valid_in = 1'b1;
         pos_in   = 2'd0;
      end else if (xfer) begin
         valid_in = !at_last;
         pos_in   = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (bnd_load) begin
         bytes_ff    <= bnd.bytes;
         nbytes_ff   <= bnd.nbytes;
         status_ff   <= bnd.status;
         // Number of results minus one; a bundle is never loaded empty.
         last_idx_ff <= bnd.nbytes + {1'b0, bnd.has_status} - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      bnd_load |-> ser_free)
      else $error("bundle loaded while the previous one is still draining");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_res) |-> at_last)
      else $error("closing status is not the last result of its bundle");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (xfer && !at_last) |=> (rsp_valid && pos_ff == $past(pos_ff) + 2'd1))
      else $error("bundle stopped before its last result");

endmodule

FILE: rtl/core/strict_base64_decoder.sv
// ----------------------------------------------------------------------------
// strict_base64_decoder
// Strict base64 decoder: one encoded character per transfer in, decoded bytes
// and a closing status out. An item enters an input register and is decoded
// in the cycle it leaves it, so a new character can be taken every cycle
// unless an item with results is held there. Items that produce no result
// (the first three characters of a group, or an empty item that is not last)
// pass through even while results are still waiting on the output. A complete
// group and a closing item produce up to four results, which leave one
// transfer per cycle from the result register while the receiver does not
// stall. An item with results waits in the input register until the last
// result of the previous one is taken.
// Status 2 (capacity) wins over status 1 (malformed); once either is set in a
// string, no further bytes come out. Write max_bytes only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strict_base64_decoder #(
   parameter int COUNT_WIDTH = sb64_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [sb64_pkg::MAX_BYTES_WIDTH-1:0]  csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_char_code,
   input  logic                                  req_is_last,
   input  logic                                  req_is_empty,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_data_byte,
   output logic                                  rsp_final_res,
   output logic [1:0]                            rsp_status
);
   import sb64_pkg::*;

   logic       ser_free;
   logic       bnd_load;
   bundle_type bnd;

   sb64_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .req_is_empty  (req_is_empty),
      .ser_free      (ser_free),
      .bnd_load      (bnd_load),
      .bnd           (bnd)
   );

   sb64_serializer u_ser (
      .clock         (clock),
      .reset         (reset),
      .bnd_load      (bnd_load),
      .bnd           (bnd),
      .ser_free      (ser_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_byte (rsp_data_byte),
      .rsp_final_res (rsp_final_res),
      .rsp_status    (rsp_status)
   );

endmodule

FILE: bench/strict_base64_decoder_tb.sv
// ----------------------------------------------------------------------------
// strict_base64_decoder_tb
// Self-checking bench for the strict base64 decoder. Encoded strings are fed
// one character per transfer. A scoreboard class decodes every accepted
// character on its own and queues the bytes and closing status it expects.
// Each result transfer is checked field by field against that queue. Both
// channels idle at random, one phase runs without idling, and the receiver
// holds off once for a long stretch. The byte limit is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strict_base64_decoder_tb;
   import sb64_pkg::*;

   localparam int BUDGET_W = COUNT_WIDTH_DEF + 2;
   localparam logic [BUDGET_W-1:0] BUDGET_MAX = '1;
   localparam int PHASE_ITEMS = 32;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      logic [7:0] data_byte;
      logic       final_res;
      status_type status;
   } decoded_type;

   // Ways a well-formed string gets broken in the random part.
   typedef enum int {
      FLAW_BAD_CHAR,
      FLAW_RAGGED,
      FLAW_EXTRA_GROUP,
      FLAW_PAD_INSIDE,
      FLAW_EMPTY
   } flaw_kind_type;

   class base64_scoreboard;
      logic [31:0]         max_bytes;
      logic [23:0]         bits;
      logic [1:0]          grp_pos;
      logic [2:0]          pads;
      logic                padded_seen;
      logic                malformed;
      logic                capacity;
      logic [BUDGET_W-1:0] budget;
      decoded_type         decoded_queue[$];
      int                  mismatches;
      int                  bytes_seen;
      int                  strings_closed;
      int                  status_seen[4];

      function new();
         max_bytes = MAX_BYTES_RESET;
         mismatches = 0;
         bytes_seen = 0;
         strings_closed = 0;
         status_seen = '{default: 0};
         clear_string();
      endfunction

      function void clear_string();
         bits = '0;
         grp_pos = '0;
         pads = '0;
         padded_seen = 1'b0;
         malformed = 1'b0;
         capacity = 1'b0;
         budget = '0;
      endfunction

      function int sextet(logic [7:0] c);
         if (c inside {[8'h41:8'h5A]}) return int'(c) - 65;
         if (c inside {[8'h61:8'h7A]}) return int'(c) - 97 + 26;
         if (c inside {[8'h30:8'h39]}) return int'(c) - 48 + 52;
         if (c == 8'h2B) return 62;
         if (c == 8'h2F) return 63;
         return -1;
      endfunction

      function void enqueue(decoded_type d);
         decoded_queue = {decoded_queue, d};
      endfunction

      function void push_byte(logic [7:0] b);
         enqueue('{b, 1'b0, ST_OK});
      endfunction

      // Called once per accepted input transfer.
      function void decode_item(logic [7:0] c, logic last, logic empty);
         int         val;
         logic [5:0] six;
         status_type st;
         logic       nothing_decoded;
         if (!empty) begin
            six = '0;
            if (grp_pos == 2'd0 && padded_seen) malformed = 1'b1;
            if (c == PAD_CHAR) begin
               if (pads != 3'd7) pads = pads + 3'd1;
            end else begin
               val = sextet(c);
               if (pads != 3'd0 || val < 0) malformed = 1'b1;
               else six = 6'(val);
            end
            bits = {bits[17:0], six};
            if (grp_pos == 2'd3) begin
               if (pads > 3'd2) malformed = 1'b1;
               if (pads != 3'd0) padded_seen = 1'b1;
               budget = (budget > BUDGET_MAX - 3) ? BUDGET_MAX : budget + 3;
               if (budget > BUDGET_W'(max_bytes)) capacity = 1'b1;
               if (!malformed && !capacity) begin
                  push_byte(bits[23:16]);
                  if (pads < 3'd2) push_byte(bits[15:8]);
                  if (pads < 3'd1) push_byte(bits[7:0]);
               end
               grp_pos = '0;
               bits = '0;
               pads = '0;
            end else begin
               grp_pos = grp_pos + 2'd1;
            end
         end
         if (last) begin
            nothing_decoded = (grp_pos == 2'd0) && (budget == '0);
            if (capacity || nothing_decoded || grp_pos != 2'd0) st = ST_CAPACITY;
            else if (malformed) st = ST_MALFORMED;
            else st = ST_OK;
            enqueue('{8'h00, 1'b1, st});
            clear_string();
         end
      endfunction

      function void flag(string what);
         if (mismatches < 10) $display("MISMATCH at %0t: %s", $realtime, what);
         mismatches++;
      endfunction

      // Called once per accepted result transfer.
      function void match_output(logic [7:0] b, logic f, logic [1:0] s);
         decoded_type want;
         if (decoded_queue.size() == 0) begin
            flag($sformatf("unexpected result byte=%02h final=%b status=%0d", b, f, s));
            return;
         end
         want = decoded_queue.pop_front();
         if (b !== want.data_byte || f !== want.final_res || s !== want.status) begin
            flag($sformatf("expected byte=%02h final=%b status=%0d, got byte=%02h final=%b status=%0d",
                           want.data_byte, want.final_res, want.status, b, f, s));
         end else if (f) begin
            strings_closed++;
            status_seen[s]++;
         end else begin
            bytes_seen++;
         end
      endfunction

      function int pending();
         return decoded_queue.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_code;
   logic        req_is_last;
   logic        req_is_empty;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_data_byte;
   logic        rsp_final_res;
   logic [1:0]  rsp_status;

   logic        steady;
   logic        hold_rx;
   bit          hold_go = 1'b0;
   int          items_sent = 0;
   logic [7:0]  str_chars[$];
   logic [31:0] limits_used[$];
   base64_scoreboard decode_sb;

   strict_base64_decoder i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_char_code(req_char_code),
      .req_is_last  (req_is_last),
      .req_is_empty (req_is_empty),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_byte(rsp_data_byte),
      .rsp_final_res(rsp_final_res),
      .rsp_status   (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results still expected", decode_sb.pending());
      $display("CHECKS FAILED");
      $finish;
   end

   // Long receiver hold-off so that the decoder backs up into its input.
   initial begin
      hold_rx = 1'b0;
      wait (hold_go);
      @(posedge clock);
      hold_rx <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rx <= 1'b0;
   end

   // Result side: check each transfer, then pick the stall for the next cycle.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            decode_sb.match_output(rsp_data_byte, rsp_final_res, rsp_status);
         end
         rsp_stall <= hold_rx || (!steady && $urandom_range(99) < 33);
      end
   end

   function automatic logic [7:0] sextet_char(logic [5:0] v);
      if (v < 6'd26) return 8'h41 + 8'(v);
      if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
      if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
      return (v == 6'd62) ? 8'h2B : 8'h2F;
   endfunction

   function automatic void append_char(logic [7:0] c);
      str_chars = {str_chars, c};
   endfunction

   task automatic send_item(input logic [7:0] c, input logic last, input logic empty);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < 33) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_is_last <= last;
      req_is_empty <= empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_sb.decode_item(c, last, empty);
      if (!(empty && !last)) items_sent++;
   endtask

   task automatic send_string(input bit close_with_empty, input bit noisy);
      int n;
      n = str_chars.size();
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(99) < 8) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
         send_item(str_chars[i], (i == n - 1) && !close_with_empty, 1'b0);
      end
      if (close_with_empty || n == 0) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
   endtask

   task automatic load_text(input string s);
      str_chars.delete();
      for (int i = 0; i < s.len(); i++) append_char(s[i]);
   endtask

   // Proper base64 text for nbytes random bytes, padded as needed.
   task automatic encode_random(input int nbytes);
      logic [23:0] word;
      int          left;
      str_chars.delete();
      left = nbytes;
      while (left > 0) begin
         word = 24'($urandom());
         append_char(sextet_char(word[23:18]));
         append_char(sextet_char(word[17:12]));
         append_char(left >= 2 ? sextet_char(word[11:6]) : PAD_CHAR);
         append_char(left >= 3 ? sextet_char(word[5:0]) : PAD_CHAR);
         left -= 3;
      end
   endtask

   task automatic random_string();
      int            nbytes;
      int            pos;
      flaw_kind_type flaw;
      nbytes = ($urandom_range(9) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 6);
      encode_random(nbytes);
      if ($urandom_range(99) >= 70) begin
         pos = $urandom_range(str_chars.size() - 1);
         flaw = flaw_kind_type'($urandom_range(4));
         case (flaw)
            FLAW_BAD_CHAR: begin
               str_chars[pos] = 8'($urandom_range(255));
            end
            FLAW_RAGGED: begin
               void'(str_chars.pop_back());
            end
            FLAW_EXTRA_GROUP: begin
               repeat (4) append_char(sextet_char(6'($urandom_range(63))));
            end
            FLAW_PAD_INSIDE: begin
               str_chars[pos] = PAD_CHAR;
            end
            FLAW_EMPTY: begin
               str_chars.delete();
            end
         endcase
      end
      send_string($urandom_range(4) == 0, 1'b1);
   endtask

   // The block must be idle before max_bytes changes; a trailing empty item
   // may still be in flight once the last result is in.
   task automatic write_max_bytes(input logic [31:0] value);
      req_valid <= 1'b0;
      while (decode_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      decode_sb.max_bytes = value;
      limits_used = {limits_used, value};
   endtask

   initial begin
      int          start;
      logic [31:0] limit;
      decode_sb = new();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_char_code = '0;
      req_is_last = 1'b0;
      req_is_empty = 1'b0;
      steady = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the limit still at its reset value.
      load_text("TWE=");
      send_string(1'b0, 1'b0);
      load_text("QQ==");
      send_string(1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      load_text("+/09azAZ");
      send_string(1'b0, 1'b0);
      str_chars = '{8'h41, 8'h00, 8'hFF, 8'h41};
      send_string(1'b0, 1'b0);
      load_text("A===");
      send_string(1'b0, 1'b0);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: limit = 32'hFFFF_FFFF;
            1: limit = 32'd0;
            2: limit = 32'($urandom_range(3, 15));
            default: limit = $urandom_range(1) ? $urandom() : 32'($urandom_range(3, 30));
         endcase
         write_max_bytes(limit);
         steady <= (ph == 2);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if (ph == 0 && items_sent - start > 15) hold_go = 1'b1;
            random_string();
         end
      end

      req_valid <= 1'b0;
      while (decode_sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d characters in %0d strings under %0d byte limits; %0d bytes decoded.",
               items_sent, decode_sb.strings_closed, limits_used.size() + 1,
               decode_sb.bytes_seen);
      $display("Closing status counts: success %0d, malformed %0d, capacity %0d.",
               decode_sb.status_seen[ST_OK], decode_sb.status_seen[ST_MALFORMED],
               decode_sb.status_seen[ST_CAPACITY]);
      if (decode_sb.mismatches == 0 && decode_sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
